### hdl/iprq_pkg.sv
// iprq_pkg: shared constants, payload types and sequencer states for the
// interrupt queue. No dependencies; every other file but iprq_ram uses it.

package iprq_pkg;

   // field widths
   localparam int VEC_W    = 7;
   localparam int LVL_W    = 5;
   localparam int MASK_W   = 4;
   localparam int PCOUNT_W = 5;
   localparam int ENTRY_W  = LVL_W + VEC_W;

   // default number of queue entries
   localparam int QUEUE_DEPTH_DEF = 16;

   // highest mask value a popped level saturates to
   localparam logic [MASK_W-1:0] MASK_MAX = 4'd15;

   // item action codes
   localparam logic ACT_RAISE   = 1'b0;
   localparam logic ACT_SERVICE = 1'b1;

   typedef struct packed {
      logic              action;
      logic [VEC_W-1:0]  req_vector;
      logic [LVL_W-1:0]  req_level;
      logic [MASK_W-1:0] cpu_mask;
   } req_type;

   typedef struct packed {
      logic                taken;
      logic [VEC_W-1:0]    taken_vector;
      logic [MASK_W-1:0]   new_mask;
      logic                dropped;
      logic [PCOUNT_W-1:0] pending_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_POP_CHK,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

endpackage

### hdl/iprq_req_if.sv
// iprq_req_if: request channel (raise / service beats) with valid/ready.
// Depends on iprq_pkg for field widths.

interface iprq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [iprq_pkg::VEC_W-1:0]    req_vector;
   logic [iprq_pkg::LVL_W-1:0]    req_level;
   logic [iprq_pkg::MASK_W-1:0]   cpu_mask;

   modport source (output valid, action, req_vector, req_level, cpu_mask, input ready);
   modport sink   (input valid, action, req_vector, req_level, cpu_mask, output ready);
endinterface

### hdl/iprq_rsp_if.sv
// iprq_rsp_if: response channel, one beat per request beat, valid/ready.
// Depends on iprq_pkg for field widths.

interface iprq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          taken;
   logic [iprq_pkg::VEC_W-1:0]    taken_vector;
   logic [iprq_pkg::MASK_W-1:0]   new_mask;
   logic                          dropped;
   logic [iprq_pkg::PCOUNT_W-1:0] pending_count;

   modport source (output valid, taken, taken_vector, new_mask, dropped, pending_count,
                   input ready);
   modport sink   (input valid, taken, taken_vector, new_mask, dropped, pending_count,
                   output ready);
endinterface

### hdl/interrupt_priority_queue.sv
// interrupt_priority_queue: top level, entry RAM, sequencer and output stage.
// Depends on iprq_pkg, iprq_req_if, iprq_rsp_if, iprq_ram and iprq_ctrl.
//
//   channel   dir   beat carries
//   req       in    action, req_vector, req_level, cpu_mask
//   rsp       out   taken, taken_vector, new_mask, dropped, pending_count
//
// Steps per beat, accept to next accept:
//   service: accept, RAM read of the top entry, compare, result; accept and
//   result alone when empty. raise: accept, scan, shift and insert, result.
//   A duplicate skips the shift after its scan; a dropped raise on a full queue
//   goes from accept straight to result.
// Reset is synchronous and empties the queue; the RAM itself is not cleared.
// The output register frees the sequencer once a beat is handed over; it
// stalls in its result state only while a previous response is still unread.

module interrupt_priority_queue #(
   parameter int QUEUE_DEPTH = iprq_pkg::QUEUE_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   iprq_req_if.sink   req,
   iprq_rsp_if.source rsp
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   iprq_pkg::req_type             req_data;
   iprq_pkg::rsp_type             res;
   logic                          done;
   logic                          res_free;
   logic                          ram_we;
   logic [IDX_W-1:0]              ram_waddr;
   logic [iprq_pkg::ENTRY_W-1:0]  ram_wdata;
   logic [IDX_W-1:0]              ram_raddr;
   logic [iprq_pkg::ENTRY_W-1:0]  ram_rdata;

   logic                          rsp_valid_ff, rsp_valid_in;
   iprq_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   assign req_data.action     = req.action;
   assign req_data.req_vector = req.req_vector;
   assign req_data.req_level  = req.req_level;
   assign req_data.cpu_mask   = req.cpu_mask;

   iprq_ram #(
      .WIDTH (iprq_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   iprq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_data  (req_data),
      .done      (done),
      .res       (res),
      .res_free  (res_free),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // output register: loads when empty or being drained
   assign res_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done && res_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.taken         = rsp_data_ff.taken;
   assign rsp.taken_vector  = rsp_data_ff.taken_vector;
   assign rsp.new_mask      = rsp_data_ff.new_mask;
   assign rsp.dropped       = rsp_data_ff.dropped;
   assign rsp.pending_count = rsp_data_ff.pending_count;

endmodule

### hdl/iprq_ram.sv
// iprq_ram: generic simple dual-port RAM, one write and one read port,
// read data registered. No dependencies.

module iprq_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/iprq_ctrl.sv
// iprq_ctrl: sequencer that scans, shifts, inserts and pops queue entries
// held in the entry RAM. Depends on iprq_pkg; drives an iprq_ram instance.

module iprq_ctrl #(
   parameter int QUEUE_DEPTH = iprq_pkg::QUEUE_DEPTH_DEF,
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   // request beat
   input  logic                              req_valid,
   output logic                              req_ready,
   input  iprq_pkg::req_type                 req_data,
   // finished result, held while done is high
   output logic                              done,
   output iprq_pkg::rsp_type                 res,
   input  logic                              res_free,
   // entry RAM
   output logic                              ram_we,
   output logic [IDX_W-1:0]                  ram_waddr,
   output logic [iprq_pkg::ENTRY_W-1:0]      ram_wdata,
   output logic [IDX_W-1:0]                  ram_raddr,
   input  logic [iprq_pkg::ENTRY_W-1:0]      ram_rdata
);

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   iprq_pkg::state_type           state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              ptr_ff, ptr_in;
   logic [CNT_W-1:0]              pos_ff, pos_in;
   logic                          dup_ff, dup_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]              rd_idx_ff, rd_idx_in;
   logic [iprq_pkg::VEC_W-1:0]    vec_ff, vec_in;
   logic [iprq_pkg::LVL_W-1:0]    lvl_ff, lvl_in;
   logic [iprq_pkg::MASK_W-1:0]   mask_ff, mask_in;
   iprq_pkg::rsp_type             res_ff, res_in;

   logic [iprq_pkg::VEC_W-1:0]    rd_vec;
   logic [iprq_pkg::LVL_W-1:0]    rd_lvl;
   logic [CNT_W-1:0]              cnt_dec;
   logic [CNT_W-1:0]              cnt_inc;
   logic [CNT_W-1:0]              ptr_dec;
   logic [CNT_W-1:0]              wr_next;

   // count reported on the response, low bits only for deep queues
   function automatic logic [iprq_pkg::PCOUNT_W-1:0] to_pcount(input logic [CNT_W-1:0] c);
      logic [CNT_W+iprq_pkg::PCOUNT_W-1:0] e;
      e = {{iprq_pkg::PCOUNT_W{1'b0}}, c};
      return e[iprq_pkg::PCOUNT_W-1:0];
   endfunction

   assign rd_vec  = ram_rdata[iprq_pkg::VEC_W-1:0];
   assign rd_lvl  = ram_rdata[iprq_pkg::ENTRY_W-1:iprq_pkg::VEC_W];
   assign cnt_dec = count_ff - 1'b1;
   assign cnt_inc = count_ff + 1'b1;
   assign ptr_dec = ptr_ff - 1'b1;
   assign wr_next = CNT_W'(rd_idx_ff) + 1'b1;

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= iprq_pkg::ST_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // working registers for the item in flight
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      dup_ff    <= dup_in;
      rd_idx_ff <= rd_idx_in;
      vec_ff    <= vec_in;
      lvl_ff    <= lvl_in;
      mask_ff   <= mask_in;
      res_ff    <= res_in;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      dup_in    = dup_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      vec_in    = vec_ff;
      lvl_in    = lvl_ff;
      mask_in   = mask_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      done      = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;

      case (state_ff)
         iprq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               vec_in  = req_data.req_vector;
               lvl_in  = req_data.req_level;
               mask_in = req_data.cpu_mask;
               ptr_in  = '0;
               pos_in  = '0;
               dup_in  = 1'b0;
               // default result: nothing taken, mask passes through
               res_in.taken         = 1'b0;
               res_in.taken_vector  = '0;
               res_in.new_mask      = req_data.cpu_mask;
               res_in.dropped       = 1'b0;
               res_in.pending_count = to_pcount(count_ff);
               if (req_data.action == iprq_pkg::ACT_SERVICE) begin
                  if (count_ff == '0) begin
                     state_in = iprq_pkg::ST_RESP;
                  end else begin
                     state_in = iprq_pkg::ST_POP_RD;
                  end
               end else if (count_ff == FULL_CNT) begin
                  res_in.dropped = 1'b1;
                  state_in       = iprq_pkg::ST_RESP;
               end else begin
                  state_in = iprq_pkg::ST_SCAN;
               end
            end
         end

         // fetch the top entry
         iprq_pkg::ST_POP_RD: begin
            ram_raddr = cnt_dec[IDX_W-1:0];
            state_in  = iprq_pkg::ST_POP_CHK;
         end

         // pop it if its level beats the mask
         iprq_pkg::ST_POP_CHK: begin
            if (rd_lvl > {1'b0, mask_ff}) begin
               res_in.taken         = 1'b1;
               res_in.taken_vector  = rd_vec;
               res_in.new_mask      = rd_lvl[iprq_pkg::LVL_W-1] ? iprq_pkg::MASK_MAX
                                                                : rd_lvl[iprq_pkg::MASK_W-1:0];
               res_in.pending_count = to_pcount(cnt_dec);
               count_in             = cnt_dec;
            end
            state_in = iprq_pkg::ST_RESP;
         end

         // read every entry: look for a duplicate vector, count lower levels
         iprq_pkg::ST_SCAN: begin
            if (ptr_ff < count_ff) begin
               ram_raddr = ptr_ff[IDX_W-1:0];
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_vec == vec_ff) begin
                  dup_in = 1'b1;
               end else if (rd_lvl < lvl_ff) begin
                  pos_in = pos_ff + 1'b1;
               end
            end else if (ptr_ff == count_ff) begin
               if (dup_ff) begin
                  res_in.dropped = 1'b1;
                  state_in       = iprq_pkg::ST_RESP;
               end else begin
                  ptr_in   = count_ff;
                  state_in = iprq_pkg::ST_SHIFT;
               end
            end
         end

         // move entries pos..count-1 up by one, top first, then insert
         iprq_pkg::ST_SHIFT: begin
            if (ptr_ff > pos_ff) begin
               ram_raddr = ptr_dec[IDX_W-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = ptr_dec[IDX_W-1:0];
               ptr_in    = ptr_dec;
            end
            if (rd_vld_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_next[IDX_W-1:0];
               ram_wdata = ram_rdata;
            end else if (ptr_ff == pos_ff) begin
               ram_we               = 1'b1;
               ram_waddr            = pos_ff[IDX_W-1:0];
               ram_wdata            = {lvl_ff, vec_ff};
               count_in             = cnt_inc;
               res_in.pending_count = to_pcount(cnt_inc);
               state_in             = iprq_pkg::ST_RESP;
            end
         end

         // hand the result to the output stage
         iprq_pkg::ST_RESP: begin
            done = 1'b1;
            if (res_free) begin
               state_in = iprq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = iprq_pkg::ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

### tb/tb_interrupt_priority_queue.sv
// tb_interrupt_priority_queue: self-checking bench for the sorted interrupt queue.
// Drives raise/service beats, predicts or types each response and compares field by field.
// Depends on iprq_pkg, iprq_req_if, iprq_rsp_if and interrupt_priority_queue.

module tb_interrupt_priority_queue;

   localparam int TAIL_ITEMS   = 100;   // last beats run without any idling
   localparam int RANDOM_ITEMS = 800;
   localparam int HOLD_AT      = 350;   // responses seen before the long rsp hold
   localparam int HOLD_CYCLES  = 300;

   typedef struct {
      iprq_pkg::req_type beat;
      bit                has_typed;   // response given by hand rather than by the predictor
      iprq_pkg::rsp_type typed_rsp;
   } irq_script_row_type;

   logic clock;
   logic reset = 1'b1;

   iprq_req_if req_bus ();
   iprq_rsp_if rsp_bus ();

   interrupt_priority_queue #(
      .QUEUE_DEPTH(iprq_pkg::QUEUE_DEPTH_DEF)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus.sink),
      .rsp  (rsp_bus.source)
   );

   // stimulus script, responses still owed, and the shadow of the queue
   irq_script_row_type         irq_script[$];
   iprq_pkg::rsp_type          awaited_outcomes[$];
   logic [iprq_pkg::VEC_W-1:0] queued_vec[iprq_pkg::QUEUE_DEPTH_DEF];
   logic [iprq_pkg::LVL_W-1:0] queued_lvl[iprq_pkg::QUEUE_DEPTH_DEF];
   int                         queued_count = 0;

   bit                beat_has_typed = 1'b0;
   iprq_pkg::rsp_type beat_typed_rsp = '0;
   bit                quiet_tail     = 1'b0;
   int                mismatch_count = 0;
   int                rsp_seen       = 0;

   // shadow step: apply one beat to the queue and return its response
   function automatic iprq_pkg::rsp_type irq_queue_step(iprq_pkg::req_type beat);
      iprq_pkg::rsp_type outcome;
      int                pos;
      bit                dup;
      outcome          = '0;
      outcome.new_mask = beat.cpu_mask;
      if (beat.action == iprq_pkg::ACT_RAISE) begin
         pos = 0;
         dup = 1'b0;
         for (int i = 0; i < queued_count; i++) begin
            if (queued_vec[i] == beat.req_vector) dup = 1'b1;
            else if (queued_lvl[i] < beat.req_level) pos++;
         end
         if (dup || queued_count >= iprq_pkg::QUEUE_DEPTH_DEF) begin
            outcome.dropped = 1'b1;
         end else begin
            // open a slot above all strictly lower levels; equal levels stay on top
            for (int i = queued_count; i > pos; i--) begin
               queued_vec[i] = queued_vec[i-1];
               queued_lvl[i] = queued_lvl[i-1];
            end
            queued_vec[pos] = beat.req_vector;
            queued_lvl[pos] = beat.req_level;
            queued_count++;
         end
      end else if (queued_count > 0) begin
         if (queued_lvl[queued_count-1] > beat.cpu_mask) begin
            outcome.taken        = 1'b1;
            outcome.taken_vector = queued_vec[queued_count-1];
            outcome.new_mask     = (queued_lvl[queued_count-1] > iprq_pkg::MASK_MAX) ?
                                   iprq_pkg::MASK_MAX :
                                   queued_lvl[queued_count-1][iprq_pkg::MASK_W-1:0];
            queued_count--;
         end
      end
      outcome.pending_count = queued_count[iprq_pkg::PCOUNT_W-1:0];
      return outcome;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void add_row(logic act, int vec, int lvl, int mask,
                                   bit has_typed, iprq_pkg::rsp_type typed_rsp);
      irq_script_row_type row;
      row.beat.action     = act;
      row.beat.req_vector = vec[iprq_pkg::VEC_W-1:0];
      row.beat.req_level  = lvl[iprq_pkg::LVL_W-1:0];
      row.beat.cpu_mask   = mask[iprq_pkg::MASK_W-1:0];
      row.has_typed       = has_typed;
      row.typed_rsp       = typed_rsp;
      irq_script.push_back(row);
   endfunction

   // clock and the single reset pulse
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   // check response beats, then record accepted request beats
   always @(posedge clock) begin : check_and_record
      iprq_pkg::rsp_type want;
      iprq_pkg::rsp_type outcome;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen++;
            if (awaited_outcomes.size() == 0) begin
               $error("response beat with no outcome pending");
               mismatch_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               check_field("taken", want.taken, rsp_bus.taken);
               check_field("taken_vector", want.taken_vector, rsp_bus.taken_vector);
               check_field("new_mask", want.new_mask, rsp_bus.new_mask);
               check_field("dropped", want.dropped, rsp_bus.dropped);
               check_field("pending_count", want.pending_count, rsp_bus.pending_count);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            outcome = irq_queue_step('{req_bus.action, req_bus.req_vector,
                                       req_bus.req_level, req_bus.cpu_mask});
            awaited_outcomes.push_back(beat_has_typed ? beat_typed_rsp : outcome);
         end
      end
   end

   // response side: short random stalls plus one long hold to back up the queue
   initial begin : rsp_side
      int  stall_left;
      bit  hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) stall_left--;
         else if (!hold_done && rsp_seen >= HOLD_AT) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5);
         end
         rsp_bus.ready <= (stall_left == 0) && !reset;
      end
   end

   // request side: build the script, walk it, then drain
   initial begin : req_side
      irq_script_row_type row;
      int                 raise_pct;
      int                 pick;
      int                 rnd;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= iprq_pkg::ACT_RAISE;
      req_bus.req_vector <= '0;
      req_bus.req_level  <= '0;
      req_bus.cpu_mask   <= '0;

      // directed: empty service, extremes, duplicate, level above NMI, FIFO order
      add_row(iprq_pkg::ACT_SERVICE, 0, 0, 0, 1,
              iprq_pkg::rsp_type'{1'b0, 7'd0, 4'd0, 1'b0, 5'd0});
      add_row(iprq_pkg::ACT_RAISE, 0, 0, 9, 1,
              iprq_pkg::rsp_type'{1'b0, 7'd0, 4'd9, 1'b0, 5'd1});
      add_row(iprq_pkg::ACT_RAISE, 127, 16, 15, 1,
              iprq_pkg::rsp_type'{1'b0, 7'd0, 4'd15, 1'b0, 5'd2});
      add_row(iprq_pkg::ACT_RAISE, 127, 3, 0, 1,
              iprq_pkg::rsp_type'{1'b0, 7'd0, 4'd0, 1'b1, 5'd2});
      add_row(iprq_pkg::ACT_RAISE, 5, 31, 6, 1,
              iprq_pkg::rsp_type'{1'b0, 7'd0, 4'd6, 1'b0, 5'd3});
      add_row(iprq_pkg::ACT_RAISE, 10, 7, 1, 0, '0);
      add_row(iprq_pkg::ACT_RAISE, 11, 7, 2, 0, '0);
      add_row(iprq_pkg::ACT_SERVICE, 99, 20, 15, 1,
              iprq_pkg::rsp_type'{1'b1, 7'd5, 4'd15, 1'b0, 5'd4});
      add_row(iprq_pkg::ACT_SERVICE, 0, 0, 15, 1,
              iprq_pkg::rsp_type'{1'b1, 7'd127, 4'd15, 1'b0, 5'd3});
      add_row(iprq_pkg::ACT_SERVICE, 0, 0, 7, 1,
              iprq_pkg::rsp_type'{1'b0, 7'd0, 4'd7, 1'b0, 5'd3});
      add_row(iprq_pkg::ACT_SERVICE, 0, 0, 6, 0, '0);
      // fill to the brim with mixed levels, then overflow
      for (int i = 0; i < 14; i++) add_row(iprq_pkg::ACT_RAISE, 40 + i, (i * 7) % 17, i, 0, '0);
      add_row(iprq_pkg::ACT_RAISE, 100, 9, 3, 1,
              iprq_pkg::rsp_type'{1'b0, 7'd0, 4'd3, 1'b1, 5'd16});
      add_row(iprq_pkg::ACT_SERVICE, 0, 0, 0, 0, '0);

      // random: phases lean toward filling or draining; small vector pool for duplicates
      raise_pct = 50;
      for (int r = 0; r < RANDOM_ITEMS; r++) begin
         if (r % 40 == 0) begin
            pick      = $urandom_range(0, 2);
            raise_pct = (pick == 0) ? 30 : (pick == 1) ? 55 : 85;
         end
         row.has_typed       = 1'b0;
         row.typed_rsp       = '0;
         row.beat.action     = ($urandom_range(0, 99) < raise_pct) ? iprq_pkg::ACT_RAISE :
                                                                     iprq_pkg::ACT_SERVICE;
         rnd = $urandom_range(0, 1) ? $urandom_range(0, 23) : $urandom_range(0, 127);
         row.beat.req_vector = rnd[iprq_pkg::VEC_W-1:0];
         pick = $urandom_range(0, 9);
         rnd  = (pick == 0) ? $urandom_range(17, 31) :
                (pick == 1) ? 16 : $urandom_range(0, 15);
         row.beat.req_level  = rnd[iprq_pkg::LVL_W-1:0];
         rnd  = $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
         row.beat.cpu_mask   = rnd[iprq_pkg::MASK_W-1:0];
         irq_script.push_back(row);
      end

      do @(posedge clock); while (reset);

      foreach (irq_script[n]) begin
         if (n >= irq_script.size() - TAIL_ITEMS) quiet_tail = 1'b1;
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         req_bus.valid      <= 1'b1;
         req_bus.action     <= irq_script[n].beat.action;
         req_bus.req_vector <= irq_script[n].beat.req_vector;
         req_bus.req_level  <= irq_script[n].beat.req_level;
         req_bus.cpu_mask   <= irq_script[n].beat.cpu_mask;
         beat_has_typed     <= irq_script[n].has_typed;
         beat_typed_rsp     <= irq_script[n].typed_rsp;
         do @(posedge clock); while (!req_bus.ready);
      end
      req_bus.valid <= 1'b0;

      // drain outstanding responses, then watch for strays
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
